@@ sv/prime_factor_fft_index_map_core_assert.svh @@
// assertion macros for the prime factor index map checker
`ifndef PRIME_FACTOR_FFT_INDEX_MAP_CORE_ASSERT_SVH
`define PRIME_FACTOR_FFT_INDEX_MAP_CORE_ASSERT_SVH

// clocked property, switched off while reset is low
`define PFFIM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("pffim assertion failed");

// clocked property that also holds across reset
`define PFFIM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pffim assertion failed");

`endif

@@ sv/pffim_pkg.sv @@
// shared constants, types and arithmetic steps of the prime factor index map
`timescale 1ns / 1ps
package pffim_pkg;

  localparam int MAX_FACTORS = 4;
  localparam int INDEX_BITS  = 16;
  localparam int VAL_W       = 17;
  localparam int T_W         = VAL_W + 2;
  localparam int REG_IDX_W   = 3;
  localparam int CNT_W       = $clog2(VAL_W);
  // digit extraction: four quotient bits per stage
  localparam int DIV_STEPS   = 4;
  localparam int DIV_STAGES  = (INDEX_BITS / DIV_STEPS) * MAX_FACTORS;
  // modular multiply: three digit bits per stage
  localparam int MM_BITS     = 18;
  localparam int MM_STEPS    = 3;
  localparam int MM_STAGES   = MM_BITS / MM_STEPS;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SAMPLE_COUNT = 3'd0,
    REG_USED_FACTORS = 3'd1,
    REG_FACTOR_A     = 3'd2,
    REG_FACTOR_B     = 3'd3,
    REG_FACTOR_C     = 3'd4,
    REG_FACTOR_D     = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FACTOR,
    ST_DIV_S,
    ST_EUC_MOD,
    ST_EUC_LOOP,
    ST_EUC_DIV,
    ST_EUC_UPD,
    ST_MULMOD,
    ST_NEXT
  } seq_state_e;

  // per-factor constants handed from the setup unit to the datapath
  typedef struct packed {
    logic [VAL_W-1:0]                  n;
    logic [MAX_FACTORS-1:0]            use_f;
    logic [MAX_FACTORS-1:0][VAL_W-1:0] p;
    logic [MAX_FACTORS-1:0][VAL_W-1:0] m0;
    logic [MAX_FACTORS-1:0][VAL_W-1:0] m1;
  } pffim_consts_t;

  // item state through the digit stages
  typedef struct packed {
    logic                              mode;
    logic [INDEX_BITS-1:0]             num;
    logic [VAL_W-1:0]                  rem;
    logic [INDEX_BITS-1:0]             orig;
    logic [MAX_FACTORS-1:0][VAL_W-1:0] c;
  } pffim_dig_t;

  // item state through the modular multiply stages
  typedef struct packed {
    logic                                mode;
    logic [MAX_FACTORS-1:0][MM_BITS-1:0] c;
    logic [MAX_FACTORS-1:0][VAL_W-1:0]   r;
  } pffim_mm_t;

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [VAL_W:0] div_step(input logic [VAL_W-1:0] rem,
                                              input logic nb,
                                              input logic [VAL_W-1:0] den);
    logic [VAL_W:0] t;
    t = {rem, nb};
    if (t >= {1'b0, den}) begin
      div_step = {1'b1, VAL_W'(t - {1'b0, den})};
    end else begin
      div_step = {1'b0, t[VAL_W-1:0]};
    end
  endfunction

  // one msb-first double-and-add step of r * m mod n
  function automatic logic [VAL_W-1:0] mulmod_step(input logic [VAL_W-1:0] r,
                                                   input logic nb,
                                                   input logic [VAL_W-1:0] m,
                                                   input logic [VAL_W-1:0] n);
    logic [VAL_W+1:0] t;
    t = {1'b0, r, 1'b0} + (nb ? {2'b00, m} : '0);
    if (t >= {2'b00, n}) t = t - {2'b00, n};
    if (t >= {2'b00, n}) t = t - {2'b00, n};
    mulmod_step = t[VAL_W-1:0];
  endfunction

  // (a + b) mod n for a, b below n
  function automatic logic [VAL_W-1:0] addmod(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b,
                                              input logic [VAL_W-1:0] n);
    logic [VAL_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= {1'b0, n}) t = t - {1'b0, n};
    addmod = t[VAL_W-1:0];
  endfunction

endpackage

@@ sv/pffim_if.sv @@
// valid/ready channel interfaces for index requests and mapped results
`timescale 1ns / 1ps
interface pffim_in_if import pffim_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [INDEX_BITS-1:0] sample_index;

  modport source (output valid, output mode, output sample_index, input ready);
  modport sink (input valid, input mode, input sample_index, output ready);
endinterface

interface pffim_out_if import pffim_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] mapped_index;

  modport source (output valid, output mapped_index, input ready);
  modport sink (input valid, input mapped_index, output ready);
endinterface

@@ sv/prime_factor_fft_index_map_core.sv @@
// top level of the prime factor (good-thomas) fft index map
//
//   channel  dir  handshake          beat contents
//   in_i     in   valid/ready        mode, sample_index
//   out_o    out  valid/ready        mapped_index
//   cfg      in   cfg_we_i           cfg_idx_i, cfg_data_i
//
// one index per cycle while in_i.ready is high; 24 pipeline stages plus the output register
// (16 digit stages, 6 modular multiply stages, 2 summing stages)
// after reset and after every register write the setup sequencer derives the
// per-factor multipliers with its bit-serial divider; in_i.ready stays low
// while it runs
// a two-entry output buffer decouples out_o.ready from in_i.ready; stalls lose nothing
`timescale 1ns / 1ps
module prime_factor_fft_index_map_core import pffim_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pffim_in_if.sink             in_i,
  pffim_out_if.source          out_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0]     cfg_data_i
);

  localparam int DIV_PER_FACTOR = DIV_STAGES / MAX_FACTORS;

  pffim_consts_t         consts;
  logic                  busy;
  logic                  en;

  pffim_dig_t            dig   [0:DIV_STAGES];
  logic                  dig_v [0:DIV_STAGES];
  pffim_mm_t             mm    [0:MM_STAGES];
  logic                  mm_v  [0:MM_STAGES];

  logic                  sa_valid_q;
  logic [VAL_W-1:0]      s01_q, s23_q;
  logic                  sb_valid_q;
  logic [INDEX_BITS-1:0] sb_idx_q;
  logic [VAL_W-1:0]      total;

  logic                  out_valid_q, skid_valid_q;
  logic [INDEX_BITS-1:0] out_idx_q, skid_idx_q;
  logic                  push, pop;

  pffim_setup u_setup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .consts_o   (consts),
    .busy_o     (busy)
  );

  // pipeline advances while the skid slot is free
  assign en         = !skid_valid_q;
  assign in_i.ready = en && !busy;

  // entry of a beat into the digit stages
  always_comb begin
    dig_v[0]    = in_i.valid && in_i.ready;
    dig[0].mode = in_i.mode;
    dig[0].num  = in_i.sample_index;
    dig[0].rem  = '0;
    dig[0].orig = in_i.sample_index;
    dig[0].c    = '0;
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_dig
    pffim_digit_stage u_dig (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .finish_i ((j % DIV_PER_FACTOR) == (DIV_PER_FACTOR - 1)),
      .p_i      (consts.p[j / DIV_PER_FACTOR]),
      .use_i    (consts.use_f[j / DIV_PER_FACTOR]),
      .valid_i  (dig_v[j]),
      .d_i      (dig[j]),
      .valid_o  (dig_v[j+1]),
      .d_o      (dig[j+1])
    );
  end

  // digits into the multiply lanes
  always_comb begin
    mm_v[0]    = dig_v[DIV_STAGES];
    mm[0].mode = dig[DIV_STAGES].mode;
    for (int l = 0; l < MAX_FACTORS; l++) begin
      mm[0].c[l] = MM_BITS'(dig[DIV_STAGES].c[l]);
      mm[0].r[l] = '0;
    end
  end

  for (genvar j = 0; j < MM_STAGES; j++) begin : g_mm
    pffim_mulmod_stage u_mm (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .consts_i (consts),
      .valid_i  (mm_v[j]),
      .d_i      (mm[j]),
      .valid_o  (mm_v[j+1]),
      .d_o      (mm[j+1])
    );
  end

  // pairwise sums, then the total with the zero-length case
  assign total = addmod(s01_q, s23_q, consts.n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_valid_q <= 1'b0;
      sb_valid_q <= 1'b0;
    end else if (en) begin
      sa_valid_q <= mm_v[MM_STAGES];
      sb_valid_q <= sa_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s01_q    <= addmod(mm[MM_STAGES].r[0], mm[MM_STAGES].r[1], consts.n);
      s23_q    <= addmod(mm[MM_STAGES].r[2], mm[MM_STAGES].r[3], consts.n);
      sb_idx_q <= (consts.n == '0) ? '0 : total[INDEX_BITS-1:0];
    end
  end

  // output register with a skid slot
  assign push = sb_valid_q && en;
  assign pop  = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !pop) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_idx_q <= skid_idx_q;
    end else if (push) begin
      if (out_valid_q && !pop) skid_idx_q <= sb_idx_q;
      else out_idx_q <= sb_idx_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.mapped_index = out_idx_q;

endmodule

@@ sv/pffim_setup.sv @@
// configuration registers and sequencer deriving the per-factor multipliers
`timescale 1ns / 1ps
module pffim_setup import pffim_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0]     cfg_data_i,
  output pffim_consts_t        consts_o,
  output logic                 busy_o
);

  logic [VAL_W-1:0]                  n_q;
  logic [REG_IDX_W-1:0]              count_q;
  logic [MAX_FACTORS-1:0][VAL_W-1:0] p_q;
  logic [MAX_FACTORS-1:0][VAL_W-1:0] m0_q, m0_d, m1_q, m1_d;
  logic [REG_IDX_W-1:0]              eff_count;
  logic [MAX_FACTORS-1:0]            use_f;

  seq_state_e                        state_q, state_d;
  logic [1:0]                        k_q, k_d;
  logic [VAL_W-1:0]                  dnum_q, dnum_d, drem_q, drem_d, dden_q, dden_d;
  logic [CNT_W-1:0]                  dcnt_q, dcnt_d;
  logic [VAL_W-1:0]                  r0_q, r0_d, r1_q, r1_d, eq_q, eq_d;
  logic signed [T_W-1:0]             t0_q, t0_d, t1_q, t1_d;
  logic [VAL_W-1:0]                  mm_r_q, mm_r_d, mm_b_q, mm_b_d;

  logic [VAL_W:0]                    dstep;
  logic [VAL_W-1:0]                  dnum_nxt, drem_nxt;
  logic                              div_last;
  logic [VAL_W-1:0]                  p_cur, s_red, inv, mm_nxt;
  logic signed [T_W-1:0]             inv_full;
  logic signed [2*T_W-1:0]           prod;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= VAL_W'(1);
      count_q <= '0;
      for (int l = 0; l < MAX_FACTORS; l++) p_q[l] <= VAL_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SAMPLE_COUNT: n_q     <= cfg_data_i;
        REG_USED_FACTORS: count_q <= cfg_data_i[REG_IDX_W-1:0];
        REG_FACTOR_A:     p_q[0]  <= cfg_data_i;
        REG_FACTOR_B:     p_q[1]  <= cfg_data_i;
        REG_FACTOR_C:     p_q[2]  <= cfg_data_i;
        REG_FACTOR_D:     p_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // factors taking part: within the count and non-zero
  always_comb begin
    eff_count = (count_q > REG_IDX_W'(MAX_FACTORS)) ? REG_IDX_W'(MAX_FACTORS) : count_q;
    for (int l = 0; l < MAX_FACTORS; l++) begin
      use_f[l] = (REG_IDX_W'(l) < eff_count) && (p_q[l] != '0);
    end
  end

  // shared bit-serial divider and helper arithmetic
  always_comb begin
    dstep    = div_step(drem_q, dnum_q[VAL_W-1], dden_q);
    drem_nxt = dstep[VAL_W-1:0];
    dnum_nxt = {dnum_q[VAL_W-2:0], dstep[VAL_W]};
    div_last = (dcnt_q == CNT_W'(VAL_W - 1));
    p_cur    = p_q[k_q];
    s_red    = (dnum_nxt >= n_q) ? dnum_nxt - n_q : dnum_nxt;
    inv_full = t0_q[T_W-1] ? t0_q + $signed({2'b00, p_cur}) : t0_q;
    inv      = (r0_q == VAL_W'(1)) ? inv_full[VAL_W-1:0] : '0;
    prod     = $signed({2'b00, eq_q}) * t1_q;
    mm_nxt   = mulmod_step(mm_r_q, mm_b_q[VAL_W-1], m0_q[k_q], n_q);
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     state_d = ST_IDLE;
      ST_FACTOR:   state_d = use_f[k_q] ? ST_DIV_S : ST_NEXT;
      ST_DIV_S:    if (div_last) state_d = (p_cur < VAL_W'(2)) ? ST_NEXT : ST_EUC_MOD;
      ST_EUC_MOD:  if (div_last) state_d = ST_EUC_LOOP;
      ST_EUC_LOOP: state_d = (r1_q == '0) ? ST_MULMOD : ST_EUC_DIV;
      ST_EUC_DIV:  if (div_last) state_d = ST_EUC_UPD;
      ST_EUC_UPD:  state_d = ST_EUC_LOOP;
      ST_MULMOD:   if (div_last) state_d = ST_NEXT;
      ST_NEXT:     state_d = (k_q == 2'(MAX_FACTORS - 1)) ? ST_IDLE : ST_FACTOR;
      default:     state_d = ST_IDLE;
    endcase
    if (cfg_we_i) state_d = ST_FACTOR;
  end

  // sequencer datapath
  always_comb begin
    k_d    = k_q;
    dnum_d = dnum_q;
    drem_d = drem_q;
    dden_d = dden_q;
    dcnt_d = dcnt_q;
    r0_d   = r0_q;
    r1_d   = r1_q;
    eq_d   = eq_q;
    t0_d   = t0_q;
    t1_d   = t1_q;
    mm_r_d = mm_r_q;
    mm_b_d = mm_b_q;
    m0_d   = m0_q;
    m1_d   = m1_q;
    unique case (state_q)
      ST_FACTOR: begin
        if (use_f[k_q]) begin
          dnum_d = n_q;
          dden_d = p_cur;
          drem_d = '0;
          dcnt_d = '0;
        end else begin
          m0_d[k_q] = '0;
          m1_d[k_q] = '0;
        end
      end
      ST_DIV_S, ST_EUC_MOD, ST_EUC_DIV: begin
        dnum_d = dnum_nxt;
        drem_d = drem_nxt;
        dcnt_d = dcnt_q + CNT_W'(1);
        if (div_last) begin
          if (state_q == ST_DIV_S) begin
            // s = n / p, then start s mod p for the inverse
            m0_d[k_q] = s_red;
            m1_d[k_q] = '0;
            dden_d    = p_cur;
            drem_d    = '0;
            dcnt_d    = '0;
            r0_d      = p_cur;
            t0_d      = '0;
            t1_d      = T_W'(1);
          end else if (state_q == ST_EUC_MOD) begin
            r1_d = drem_nxt;
          end else begin
            eq_d = dnum_nxt;
            r0_d = r1_q;
            r1_d = drem_nxt;
          end
        end
      end
      ST_EUC_LOOP: begin
        if (r1_q == '0) begin
          mm_r_d = '0;
          mm_b_d = inv;
          dcnt_d = '0;
        end else begin
          dnum_d = r0_q;
          dden_d = r1_q;
          drem_d = '0;
          dcnt_d = '0;
        end
      end
      ST_EUC_UPD: begin
        t0_d = t1_q;
        t1_d = t0_q - prod[T_W-1:0];
      end
      ST_MULMOD: begin
        mm_r_d = mm_nxt;
        mm_b_d = {mm_b_q[VAL_W-2:0], 1'b0};
        dcnt_d = dcnt_q + CNT_W'(1);
        if (div_last) m1_d[k_q] = mm_nxt;
      end
      ST_NEXT: k_d = k_q + 2'(1);
      default: ;
    endcase
    if (cfg_we_i) k_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FACTOR;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dnum_q <= dnum_d;
    drem_q <= drem_d;
    dden_q <= dden_d;
    dcnt_q <= dcnt_d;
    r0_q   <= r0_d;
    r1_q   <= r1_d;
    eq_q   <= eq_d;
    t0_q   <= t0_d;
    t1_q   <= t1_d;
    mm_r_q <= mm_r_d;
    mm_b_q <= mm_b_d;
    m0_q   <= m0_d;
    m1_q   <= m1_d;
  end

  assign consts_o = '{n: n_q, use_f: use_f, p: p_q, m0: m0_q, m1: m1_q};
  assign busy_o   = (state_q != ST_IDLE);

endmodule

@@ sv/pffim_digit_stage.sv @@
// pipeline stage: four quotient bits of the mixed-radix digit extraction
`timescale 1ns / 1ps
module pffim_digit_stage import pffim_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             finish_i,
  input  logic [VAL_W-1:0] p_i,
  input  logic             use_i,
  input  logic             valid_i,
  input  pffim_dig_t       d_i,
  output logic             valid_o,
  output pffim_dig_t       d_o
);

  pffim_dig_t     d_d, d_q;
  logic           valid_q;
  logic [VAL_W:0] st;

  // restoring division steps, digit hand-off on the last stage of a factor
  always_comb begin
    d_d = d_i;
    st  = '0;
    for (int b = 0; b < DIV_STEPS; b++) begin
      st      = div_step(d_d.rem, d_d.num[INDEX_BITS-1], p_i);
      d_d.rem = st[VAL_W-1:0];
      d_d.num = {d_d.num[INDEX_BITS-2:0], st[VAL_W]};
    end
    if (finish_i) begin
      d_d.c    = {(use_i ? d_d.rem : '0), d_d.c[MAX_FACTORS-1:1]};
      d_d.num  = use_i ? d_d.num : d_d.orig;
      d_d.orig = d_d.num;
      d_d.rem  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) d_q <= d_d;
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

@@ sv/pffim_mulmod_stage.sv @@
// pipeline stage: three double-and-add steps of digit times multiplier mod n
`timescale 1ns / 1ps
module pffim_mulmod_stage import pffim_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  pffim_consts_t consts_i,
  input  logic          valid_i,
  input  pffim_mm_t     d_i,
  output logic          valid_o,
  output pffim_mm_t     d_o
);

  pffim_mm_t        d_d, d_q;
  logic             valid_q;
  logic [VAL_W-1:0] m;

  // each lane works on its own factor
  always_comb begin
    d_d = d_i;
    m   = '0;
    for (int l = 0; l < MAX_FACTORS; l++) begin
      m = d_i.mode ? consts_i.m1[l] : consts_i.m0[l];
      for (int b = 0; b < MM_STEPS; b++) begin
        d_d.r[l] = mulmod_step(d_d.r[l], d_d.c[l][MM_BITS-1], m, consts_i.n);
        d_d.c[l] = {d_d.c[l][MM_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) d_q <= d_d;
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

@@ sv/pffim_checker.sv @@
// port-level checker for the prime factor index map, bound to the top level
`timescale 1ns / 1ps
`include "prime_factor_fft_index_map_core_assert.svh"
module pffim_port_checker import pffim_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [INDEX_BITS-1:0] out_index_i,
  input logic                  cfg_we_i
);

  // a register write restarts the setup, so no beat is taken right after
  `PFFIM_ASSERT(a_cfg_blocks_input, clk_i, rst_ni, cfg_we_i |=> !in_ready_i)

  // coming out of reset nothing is offered and nothing is taken
  `PFFIM_ASSERT_ALWAYS(a_reset_quiet, clk_i, $rose(rst_ni) |-> !out_valid_i && !in_ready_i)

  // a stalled result stays offered
  `PFFIM_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i)

  // a stalled result keeps its value
  `PFFIM_ASSERT(a_out_stable, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> $stable(out_index_i))

endmodule

bind prime_factor_fft_index_map_core pffim_port_checker u_pffim_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_index_i (out_o.mapped_index),
  .cfg_we_i    (cfg_we_i)
);

@@ bench/pffim_checker.sv @@
// checker for the prime factor index map: watches the channels, predicts and compares
`timescale 1ns / 1ps
module pffim_checker import pffim_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pffim_in_if                  in_mon,
  pffim_out_if                 out_mon,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [VAL_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o
);

  // shadow copy of the configuration registers
  logic [VAL_W-1:0]     length_q;
  logic [2:0]           nfactors_q;
  logic [VAL_W-1:0]     factor_q [MAX_FACTORS];
  logic [INDEX_BITS-1:0] mapped_fifo [$];

  // exact inverse of a modulo m, 0 when a and m share a factor
  function automatic longint unsigned inverse_mod(longint unsigned a, longint unsigned m);
    longint r0, r1, t0, t1, q, rt, tt;
    r0 = longint'(m);
    r1 = longint'(a % m);
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      rt = r0 - q * r1;
      tt = t0 - q * t1;
      r0 = r1;
      r1 = rt;
      t0 = t1;
      t1 = tt;
    end
    if (r0 != 1) return 0;
    if (t0 < 0) t0 += longint'(m);
    return longint'(t0);
  endfunction

  // good-thomas permuted index for one request
  function automatic logic [INDEX_BITS-1:0] permuted_index(logic mode,
                                                          logic [INDEX_BITS-1:0] idx);
    longint unsigned n, cnt, acc, dv, p, c, s, term, inv;
    n   = length_q;
    cnt = nfactors_q;
    acc = 0;
    dv  = 1;
    if (cnt > MAX_FACTORS) cnt = MAX_FACTORS;
    if (n == 0) return '0;
    for (int k = 0; k < cnt; k++) begin
      p = factor_q[k];
      if (p != 0) begin
        c = (idx / dv) % p;
        s = n / p;
        if (!mode) begin
          term = (c * s) % n;
        end else begin
          inv  = (p >= 2) ? inverse_mod(s, p) : 0;
          term = (((c * s) % n) * inv) % n;
        end
        acc = (acc + term) % n;
        dv  = dv * p;
        if (dv > (64'd1 << 40)) dv = 64'd1 << 40;
      end
    end
    return acc[INDEX_BITS-1:0];
  endfunction

  assign pending_o = mapped_fifo.size();

  // register writes, accepted requests and result beats
  always @(posedge clk_i or negedge rst_ni) begin
    logic [INDEX_BITS-1:0] want;
    if (!rst_ni) begin
      length_q     <= 1;
      nfactors_q   <= 0;
      for (int k = 0; k < MAX_FACTORS; k++) factor_q[k] <= 1;
      mapped_fifo.delete();
      fail_count_o <= 0;
      checked_o    <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        mapped_fifo.push_back(permuted_index(in_mon.mode, in_mon.sample_index));
      if (out_mon.valid && out_mon.ready) begin
        if (mapped_fifo.size() == 0) begin
          $display("%0t: unexpected result beat, mapped_index %0d", $time,
                   out_mon.mapped_index);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = mapped_fifo.pop_front();
          checked_o <= checked_o + 1;
          if (want !== out_mon.mapped_index) begin
            $display("%0t: mapped_index mismatch, expected %0d, actual %0d", $time,
                     want, out_mon.mapped_index);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_SAMPLE_COUNT: length_q    <= cfg_data_i;
          REG_USED_FACTORS: nfactors_q  <= cfg_data_i[2:0];
          REG_FACTOR_A:     factor_q[0] <= cfg_data_i;
          REG_FACTOR_B:     factor_q[1] <= cfg_data_i;
          REG_FACTOR_C:     factor_q[2] <= cfg_data_i;
          REG_FACTOR_D:     factor_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ bench/tb_top.sv @@
// stimulus, configuration phases and verdict for the prime factor index map
`timescale 1ns / 1ps
module tb_top;
  import pffim_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd6;
  localparam int                   CYCLE_LIMIT  = 2000000;
  localparam int                   NUM_PHASES   = 15;
  localparam int                   RAND_PER_PH  = 50;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [VAL_W-1:0]     cfg_data;
  int                   fail_count, pending, checked;
  int                   cycles, beats_sent;
  int                   src_idle_pct, snk_idle_pct;
  logic [VAL_W-1:0]     cur_len;

  pffim_in_if  req_if ();
  pffim_out_if res_if ();

  prime_factor_fft_index_map_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  pffim_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (req_if),
    .out_mon      (res_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result back-pressure
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // one register write per edge, write enable held across a burst
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  // wait until every expected result is back, then let the pipe drain
  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic load_config(logic [VAL_W-1:0] n, logic [2:0] used,
                             logic [VAL_W-1:0] fa, logic [VAL_W-1:0] fb,
                             logic [VAL_W-1:0] fc, logic [VAL_W-1:0] fd);
    // no request beat stays offered across the register writes
    req_if.valid <= 1'b0;
    wait_drained();
    write_reg(REG_SAMPLE_COUNT, n);
    write_reg(REG_USED_FACTORS, VAL_W'(used));
    write_reg(REG_FACTOR_A, fa);
    write_reg(REG_FACTOR_B, fb);
    write_reg(REG_FACTOR_C, fc);
    write_reg(REG_FACTOR_D, fd);
    write_reg(REG_UNMAPPED, '1);
    cfg_we  <= 1'b0;
    cur_len  = n;
  endtask

  // idling schedule follows the count of beats sent
  task automatic update_idling();
    if (beats_sent < 260) begin
      src_idle_pct = 7;
      snk_idle_pct = 77;
    end else if (beats_sent < 520) begin
      src_idle_pct = 77;
      snk_idle_pct = 7;
    end else begin
      src_idle_pct = 0;
      snk_idle_pct = 0;
    end
  endtask

  // present one request beat and hold it until accepted
  task automatic send_request(logic mode, logic [INDEX_BITS-1:0] idx);
    update_idling();
    req_if.valid        <= 1'b1;
    req_if.mode         <= mode;
    req_if.sample_index <= idx;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    beats_sent++;
    if ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  // random index: mostly inside the transform, sometimes anywhere
  function automatic logic [INDEX_BITS-1:0] pick_index();
    if (cur_len != 0 && $urandom_range(9) < 8)
      return INDEX_BITS'($urandom_range(cur_len - 1));
    return INDEX_BITS'($urandom);
  endfunction

  initial begin
    logic [VAL_W-1:0] n, fa, fb, fc, fd;
    logic [2:0]       used;
    cycles = 0;
    beats_sent = 0;
    src_idle_pct = 7;
    snk_idle_pct = 77;
    cur_len = 1;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.mode = 1'b0;
    req_if.sample_index = '0;
    res_if.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // fixed settings first, then random coprime factor sets
      case (ph)
        0: ;
        1: load_config(15, 2, 3, 5, 1, 1);
        2: load_config(60, 3, 4, 3, 5, 1);
        3: load_config(5040, 4, 16, 9, 5, 7);
        4: load_config(65536, 1, 65536, 1, 1, 1);
        5: load_config(0, 2, 3, 5, 1, 1);
        6: load_config(5040, 7, 16, 9, 5, 7);
        7: load_config(63, 3, 7, 0, 9, 1);
        8: load_config(24, 2, 4, 6, 1, 1);
        9: load_config(65535, 4, 65536, 65536, 65536, 3);
        10: load_config('1, 4, '1, '1, 0, '1);
        default: begin
          used = 3'($urandom_range(1, 4));
          fa = 17'(1 << $urandom_range(1, 5));
          fb = ($urandom_range(1)) ? 17'd9 : 17'd27;
          fc = ($urandom_range(1)) ? 17'd5 : 17'd25;
          fd = 17'($urandom_range(2) == 0 ? 7 : ($urandom_range(1) ? 11 : 13));
          n  = fa;
          if (used > 1) n = n * fb;
          if (used > 2) n = n * fc;
          if (used > 3) n = n * fd;
          load_config(n, used, fa, fb, fc, fd);
        end
      endcase
      // short directed pair: field extremes and both modes
      if (ph < 11) begin
        send_request(ph[0], '0);
        send_request(~ph[0], (ph % 3 == 0) ? '1 : INDEX_BITS'(cur_len - 1));
      end
      for (int k = 0; k < RAND_PER_PH; k++)
        send_request(1'($urandom), pick_index());
    end
    req_if.valid <= 1'b0;

    wait_drained();
    $display("sent %0d index requests over %0d register settings, %0d results checked",
             beats_sent, NUM_PHASES, checked);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
